// ===== src/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants for the heightmap box smoother
// Grid limits, field widths, register codes, window column types and the
// divisor codes used by the scaling pipeline.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // grid limits
  localparam int MAX_COLS  = 512;
  localparam int ROW_LIMIT = 4096;
  localparam int COL_W     = $clog2(MAX_COLS);        // column position
  localparam int COLS_W    = $clog2(MAX_COLS + 1);    // column count
  localparam int ROW_W     = $clog2(ROW_LIMIT);       // row position
  localparam int ROWS_W    = $clog2(ROW_LIMIT + 1);   // row count

  // register and field widths
  localparam int SAMPLE_W   = 8;
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 10;
  localparam int SCALE_W    = 12;
  localparam int OFFSET_W   = 24;
  localparam int HEIGHT_W   = 25;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((HEIGHT_W + 7) / 8) * 8;

  // compare widths for clamping the size registers
  localparam int GC_W = (COLS_CFG_W > COLS_W) ? COLS_CFG_W : COLS_W;
  localparam int GR_W = (ROWS_CFG_W > ROWS_W) ? ROWS_CFG_W : ROWS_W;

  // reset values of the registers
  localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RST     = ROWS_CFG_W'(257);
  localparam logic [COLS_CFG_W-1:0] GRID_COLS_RST     = COLS_CFG_W'(257);
  localparam logic [SCALE_W-1:0]    HEIGHT_SCALE_RST  = SCALE_W'(768);
  localparam logic [OFFSET_W-1:0]   HEIGHT_OFFSET_RST = '0;

  // datapath widths
  localparam int CSUM_W = SAMPLE_W + 2;       // one column, three rows
  localparam int SUM_W  = SAMPLE_W + 4;       // nine samples
  localparam int PROD_W = SUM_W + SCALE_W;    // sum times scale, plus rounding
  localparam int MEAN_W = 20;                 // largest mean is 255 * 4095
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 28;
  // ceil(2^28 / d); exact for every dividend below 2^24
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(89478486);
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(29826162);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS,
    REG_GRID_COLS,
    REG_HEIGHT_SCALE,
    REG_HEIGHT_OFFSET
  } cfg_reg_t;

  // neighbourhood size
  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_4,
    DIV_6,
    DIV_9
  } div_t;

  // one window column: rows r-2, r-1, r
  typedef struct packed {
    logic [SAMPLE_W-1:0] row_up;
    logic [SAMPLE_W-1:0] row_mid;
    logic [SAMPLE_W-1:0] row_new;
  } col_t;

  // column sums starting at the top row, the middle row and the bottom row
  typedef struct packed {
    logic [CSUM_W-1:0]   rows3;
    logic [SAMPLE_W:0]   rows2;
    logic [SAMPLE_W-1:0] rows1;
  } colsum_t;

  // one result request into the scaling pipeline
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    div_t             div;
    logic             last;
  } res_req_t;

  // count = (3 - top) * (3 - left)
  function automatic div_t div_code(input logic [1:0] top, input logic [1:0] left);
    div_t d;
    case ({top, left})
      4'b0000:          d = DIV_9;
      4'b0001, 4'b0100: d = DIV_6;
      4'b0010, 4'b1000: d = DIV_3;
      4'b0101:          d = DIV_4;
      4'b0110, 4'b1001: d = DIV_2;
      default:          d = DIV_1;
    endcase
    return d;
  endfunction

  function automatic logic [CSUM_W-1:0] col_pick(input colsum_t s, input logic [1:0] top);
    logic [CSUM_W-1:0] v;
    case (top)
      2'd0:    v = s.rows3;
      2'd1:    v = CSUM_W'(s.rows2);
      default: v = CSUM_W'(s.rows1);
    endcase
    return v;
  endfunction

endpackage

// ===== src/hbs_line_store.sv =====
// ----------------------------------------------------------------------------
// hbs_line_store: the two previous rows
// Read at the column of the new sample, middle row rewritten at once, the
// upper row takes the old middle entry in the following cycle.
// ----------------------------------------------------------------------------
module hbs_line_store (
  input  logic                         clk,
  input  logic                         rd,
  input  logic                         wb,
  input  logic [hbs_pkg::COL_W-1:0]    addr,
  input  logic [hbs_pkg::SAMPLE_W-1:0] sample,
  output hbs_pkg::col_t                col
);

  logic [hbs_pkg::SAMPLE_W-1:0] upper  [hbs_pkg::MAX_COLS];
  logic [hbs_pkg::SAMPLE_W-1:0] middle [hbs_pkg::MAX_COLS];
  logic [hbs_pkg::SAMPLE_W-1:0] up_rd;
  logic [hbs_pkg::SAMPLE_W-1:0] mid_rd;
  logic [hbs_pkg::SAMPLE_W-1:0] smp_q;
  logic [hbs_pkg::COL_W-1:0]    addr_q;

  always_ff @(posedge clk) begin
    if (rd) begin
      up_rd          <= upper[addr];
      mid_rd         <= middle[addr];
      middle[addr]   <= sample;
      smp_q          <= sample;
      addr_q         <= addr;
    end
  end

  // row r-1 moves up to r-2
  always_ff @(posedge clk) begin
    if (wb) begin
      upper[addr_q] <= mid_rd;
    end
  end

  assign col.row_up  = up_rd;
  assign col.row_mid = mid_rd;
  assign col.row_new = smp_q;

endmodule

// ===== src/hbs_col_cell.sv =====
// ----------------------------------------------------------------------------
// hbs_col_cell: one column of the 3x3 window
// Holds three samples, passes them to the next cell on shift and offers its
// partial column sums.
// ----------------------------------------------------------------------------
module hbs_col_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  hbs_pkg::col_t    col_in,
  output hbs_pkg::col_t    col_q,
  output hbs_pkg::colsum_t sums
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (shift) begin
      col_q <= col_in;
    end
  end

  always_comb begin
    sums.rows1 = col_q.row_new;
    sums.rows2 = {1'b0, col_q.row_mid} + {1'b0, col_q.row_new};
    sums.rows3 = hbs_pkg::CSUM_W'(col_q.row_up) + hbs_pkg::CSUM_W'(sums.rows2);
  end

endmodule

// ===== src/hbs_scale_pipe.sv =====
// ----------------------------------------------------------------------------
// hbs_scale_pipe: sum to smoothed height
// sum * scale, rounded divide by the neighbourhood size through shifts and a
// reciprocal multiply, then offset; ends in the output register, stalls as a whole.
// ----------------------------------------------------------------------------
module hbs_scale_pipe (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  hbs_pkg::res_req_t                   req,
  input  logic [hbs_pkg::SCALE_W-1:0]         scale,
  input  logic [hbs_pkg::OFFSET_W-1:0]        offset,
  output logic                                en,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] out_value,
  output logic                                out_last
);

  localparam int MUL_W = hbs_pkg::PROD_W + hbs_pkg::RECIP_W;

  // stage 0: request
  logic                       v0;
  hbs_pkg::res_req_t          req0;
  // stage 1: scaled sum
  logic                       v1;
  logic [hbs_pkg::PROD_W-1:0] prod1;
  hbs_pkg::div_t              div1;
  logic                       last1;
  // stage 2: mean
  logic                       v2;
  logic [hbs_pkg::MEAN_W-1:0] mean2;
  logic                       last2;

  logic [2:0]                  half;
  logic [1:0]                  pre;
  logic                        use_m;
  logic [hbs_pkg::RECIP_W-1:0] m;
  logic [hbs_pkg::PROD_W:0]    x_full;
  logic [hbs_pkg::PROD_W:0]    x_sh;
  logic [hbs_pkg::PROD_W-1:0]  x;
  logic [MUL_W-1:0]            mult;
  logic [hbs_pkg::MEAN_W-1:0]  mean;

  assign en = !out_valid || out_ready;

  // halves round up; 6 is a halving then a third
  always_comb begin
    half  = 3'd0;
    pre   = 2'd0;
    use_m = 1'b0;
    m     = hbs_pkg::RECIP3;
    case (div1)
      hbs_pkg::DIV_2: begin
        half = 3'd1;
        pre  = 2'd1;
      end
      hbs_pkg::DIV_3: begin
        half  = 3'd1;
        use_m = 1'b1;
      end
      hbs_pkg::DIV_4: begin
        half = 3'd2;
        pre  = 2'd2;
      end
      hbs_pkg::DIV_6: begin
        half  = 3'd3;
        pre   = 2'd1;
        use_m = 1'b1;
      end
      hbs_pkg::DIV_9: begin
        half  = 3'd4;
        use_m = 1'b1;
        m     = hbs_pkg::RECIP9;
      end
      default: begin
        half = 3'd0;
      end
    endcase
  end

  always_comb begin
    x_full = {1'b0, prod1} + (hbs_pkg::PROD_W + 1)'(half);
    x_sh   = x_full >> pre;
    x      = x_sh[hbs_pkg::PROD_W-1:0];
    mult   = MUL_W'(x) * MUL_W'(m);
    mean   = use_m ? mult[hbs_pkg::RECIP_SHIFT +: hbs_pkg::MEAN_W]
                   : x[hbs_pkg::MEAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= req_valid;
      v1        <= v0;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req0      <= req;
      prod1     <= hbs_pkg::PROD_W'(req0.sum) * hbs_pkg::PROD_W'(scale);
      div1      <= req0.div;
      last1     <= req0.last;
      mean2     <= mean;
      last2     <= last1;
      out_value <= $signed({{(hbs_pkg::HEIGHT_W - hbs_pkg::MEAN_W){1'b0}}, mean2})
                 + $signed({offset[hbs_pkg::OFFSET_W-1], offset});
      out_last  <= last2;
    end
  end

endmodule

// ===== src/heightmap_box_smoother_top.sv =====
// ----------------------------------------------------------------------------
// heightmap_box_smoother_top: 3x3 edge-normalized box filter on a height grid
// Raw height bytes in raster order, smoothed scaled heights out, one row and
// one column behind the input; the final row is flushed by its own samples.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  --------  ---  -----------------------------  ---------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0]  raw_sample
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[24:0] smoothed_height
//                                                tlast       end_of_grid
//  cfg       in   cfg_we (no wait)               cfg_index, cfg_wdata
//
//  For each item the line store is read, then the window shifts, then the
//  results it causes (0 to 4) are issued one a cycle, while the output does
//  not stall, into the scaling pipeline, which passes each one through its
//  request, scaled-sum, mean and output registers.
//  Reset (rst, synchronous) clears the window, counters, pending results and
//  loads the register defaults; the line stores are not cleared.
//  A stalled output holds the whole pipeline; input is taken again once all
//  results of the current item are issued, even while they are in flight.
// ----------------------------------------------------------------------------
module heightmap_box_smoother_top (
  input  logic                              clk,
  input  logic                              rst,
  // input items; tdata: raw_sample [7:0]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hbs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // result items; tdata: smoothed_height [24:0], zero fill above
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hbs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // register writes
  input  logic                              cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbs_pkg::CFG_W-1:0]         cfg_wdata
);

  // registers
  logic [hbs_pkg::ROWS_CFG_W-1:0] grid_rows;
  logic [hbs_pkg::COLS_CFG_W-1:0] grid_cols;
  logic [hbs_pkg::SCALE_W-1:0]    height_scale;
  logic [hbs_pkg::OFFSET_W-1:0]   height_offset;

  // position of the next sample
  logic [hbs_pkg::ROW_W-1:0] row_cnt;
  logic [hbs_pkg::COL_W-1:0] col_cnt;

  // item sequencing
  logic       load_pend;          // line store data arrives, shift the window
  logic [3:0] res_mask;           // results still to issue, in order
  logic [1:0] top_a, top_b;       // first window row: row r-1 / row r result
  logic [1:0] left_a, left_b;     // first window column: column c-1 / c result

  logic accept;
  logic issue;
  logic pipe_en;

  // clamped sizes
  logic [hbs_pkg::COLS_W-1:0] ncols;
  logic [hbs_pkg::ROWS_W-1:0] nrows;

  // current position
  logic                       wrap_c;
  logic [hbs_pkg::COL_W-1:0]  c_cur;
  logic [hbs_pkg::ROWS_W-1:0] r_inc;
  logic [hbs_pkg::ROW_W-1:0]  r_cur;
  logic [hbs_pkg::COLS_W-1:0] c_plus;
  logic [hbs_pkg::ROWS_W-1:0] r_plus;
  logic                       last_col;
  logic                       last_row;
  logic [3:0]                 new_mask;

  // window
  hbs_pkg::col_t    ls_col;
  hbs_pkg::col_t    col0, col1;
  hbs_pkg::colsum_t cs0, cs1, cs2;

  // issue selection
  logic [3:0]              low_bit;
  logic [1:0]              sel_top;
  logic [1:0]              sel_left;
  hbs_pkg::res_req_t       req;
  logic signed [hbs_pkg::HEIGHT_W-1:0] out_value;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= hbs_pkg::GRID_ROWS_RST;
      grid_cols     <= hbs_pkg::GRID_COLS_RST;
      height_scale  <= hbs_pkg::HEIGHT_SCALE_RST;
      height_offset <= hbs_pkg::HEIGHT_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (hbs_pkg::cfg_reg_t'(cfg_index))
        hbs_pkg::REG_GRID_ROWS:     grid_rows     <= cfg_wdata[hbs_pkg::ROWS_CFG_W-1:0];
        hbs_pkg::REG_GRID_COLS:     grid_cols     <= cfg_wdata[hbs_pkg::COLS_CFG_W-1:0];
        hbs_pkg::REG_HEIGHT_SCALE:  height_scale  <= cfg_wdata[hbs_pkg::SCALE_W-1:0];
        hbs_pkg::REG_HEIGHT_OFFSET: height_offset <= cfg_wdata[hbs_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- position
  // zero acts as one, oversize acts as the limit
  always_comb begin
    if (grid_cols == '0) begin
      ncols = hbs_pkg::COLS_W'(1);
    end else if (hbs_pkg::GC_W'(grid_cols) > hbs_pkg::GC_W'(hbs_pkg::MAX_COLS)) begin
      ncols = hbs_pkg::COLS_W'(hbs_pkg::MAX_COLS);
    end else begin
      ncols = hbs_pkg::COLS_W'(grid_cols);
    end
    if (grid_rows == '0) begin
      nrows = hbs_pkg::ROWS_W'(1);
    end else if (hbs_pkg::GR_W'(grid_rows) > hbs_pkg::GR_W'(hbs_pkg::ROW_LIMIT)) begin
      nrows = hbs_pkg::ROWS_W'(hbs_pkg::ROW_LIMIT);
    end else begin
      nrows = hbs_pkg::ROWS_W'(grid_rows);
    end
  end

  // counters beyond a shrunken size wrap before the sample is placed
  always_comb begin
    wrap_c   = hbs_pkg::COLS_W'(col_cnt) >= ncols;
    c_cur    = wrap_c ? '0 : col_cnt;
    r_inc    = hbs_pkg::ROWS_W'(row_cnt) + hbs_pkg::ROWS_W'(wrap_c);
    r_cur    = (r_inc >= nrows) ? '0 : r_inc[hbs_pkg::ROW_W-1:0];
    c_plus   = hbs_pkg::COLS_W'(c_cur) + hbs_pkg::COLS_W'(1);
    r_plus   = hbs_pkg::ROWS_W'(r_cur) + hbs_pkg::ROWS_W'(1);
    last_col = c_plus == ncols;
    last_row = r_plus == nrows;
    // column c-1 then column c; within each, row r-1 then row r
    new_mask[0] = (c_cur != '0) && (r_cur != '0);
    new_mask[1] = (c_cur != '0) && last_row;
    new_mask[2] = last_col && (r_cur != '0);
    new_mask[3] = last_col && last_row;
  end

  assign s_axis_tready = !load_pend && (res_mask == '0);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : r_plus[hbs_pkg::ROW_W-1:0];
      end else begin
        col_cnt <= c_plus[hbs_pkg::COL_W-1:0];
        row_cnt <= r_cur;
      end
    end
  end

  // ----------------------------------------------------------- sequencing
  always_comb begin
    low_bit = res_mask & (~res_mask + 4'd1);
    if (res_mask[0]) begin
      sel_top  = top_a;
      sel_left = left_a;
    end else if (res_mask[1]) begin
      sel_top  = top_b;
      sel_left = left_a;
    end else if (res_mask[2]) begin
      sel_top  = top_a;
      sel_left = left_b;
    end else begin
      sel_top  = top_b;
      sel_left = left_b;
    end
  end

  assign issue = !load_pend && (res_mask != '0) && pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pend <= 1'b0;
      res_mask  <= '0;
    end else if (accept) begin
      load_pend <= 1'b1;
      res_mask  <= new_mask;
    end else begin
      load_pend <= 1'b0;
      if (issue) begin
        res_mask <= res_mask & ~low_bit;
      end
    end
  end

  // window extent per result, fixed for the item
  always_ff @(posedge clk) begin
    if (accept) begin
      top_a  <= (r_cur >= hbs_pkg::ROW_W'(2)) ? 2'd0 : 2'd1;
      top_b  <= (r_cur != '0) ? 2'd1 : 2'd2;
      left_a <= (c_cur >= hbs_pkg::COL_W'(2)) ? 2'd0 : 2'd1;
      left_b <= (c_cur != '0) ? 2'd1 : 2'd2;
    end
  end

  // --------------------------------------------------------------- window
  hbs_line_store u_line_store (
    .clk    (clk),
    .rd     (accept),
    .wb     (load_pend),
    .addr   (c_cur),
    .sample (s_axis_tdata[hbs_pkg::SAMPLE_W-1:0]),
    .col    (ls_col)
  );

  // cell 0 holds column c, cell 1 column c-1, cell 2 column c-2
  hbs_col_cell u_cell0 (
    .clk    (clk),
    .rst    (rst),
    .shift  (load_pend),
    .col_in (ls_col),
    .col_q  (col0),
    .sums   (cs0)
  );

  hbs_col_cell u_cell1 (
    .clk    (clk),
    .rst    (rst),
    .shift  (load_pend),
    .col_in (col0),
    .col_q  (col1),
    .sums   (cs1)
  );

  hbs_col_cell u_cell2 (
    .clk    (clk),
    .rst    (rst),
    .shift  (load_pend),
    .col_in (col1),
    .col_q  (),
    .sums   (cs2)
  );

  // sum over the in-grid part of the window
  always_comb begin
    req.sum = hbs_pkg::SUM_W'(hbs_pkg::col_pick(cs0, sel_top))
            + ((sel_left != 2'd2) ? hbs_pkg::SUM_W'(hbs_pkg::col_pick(cs1, sel_top))
                                  : hbs_pkg::SUM_W'(0))
            + ((sel_left == 2'd0) ? hbs_pkg::SUM_W'(hbs_pkg::col_pick(cs2, sel_top))
                                  : hbs_pkg::SUM_W'(0));
    req.div  = hbs_pkg::div_code(sel_top, sel_left);
    req.last = low_bit[3];
  end

  // ---------------------------------------------------------------- scale
  hbs_scale_pipe u_scale_pipe (
    .clk       (clk),
    .rst       (rst),
    .req_valid (issue),
    .req       (req),
    .scale     (height_scale),
    .offset    (height_offset),
    .en        (pipe_en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(hbs_pkg::OUT_TDATA_W - hbs_pkg::HEIGHT_W){1'b0}}, out_value};

endmodule

// ===== tb/heightmap_box_smoother_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_box_smoother_top_tb: self-checking bench for the height smoother
// Streams raw height bytes as whole grids, predicts every smoothed height and
// end-of-grid flag, and checks each result item in order. Covers corners,
// edges and interior points, degenerate and oversize grid sizes, size changes
// inside a grid, random idling on both sides and long output back-pressure.
// ----------------------------------------------------------------------------
module heightmap_box_smoother_top_tb;

  // settle time after the last result: item path plus scaling pipeline
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_PRINTS    = 100;

  // one expected result item
  typedef struct {
    logic [hbs_pkg::HEIGHT_W-1:0] height;
    logic                         last;
  } height_rec_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [hbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // raw_sample [7:0]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // smoothed_height [24:0], zeros above
  logic                            m_axis_tlast;  // end_of_grid
  logic                            cfg_we = 1'b0;
  logic [hbs_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [hbs_pkg::CFG_W-1:0]       cfg_wdata = '0;

  // idling controls for the sender and the receiver
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  int sink_hold_req = 0;   // stall request, picked up by the receiver process
  int sink_hold_left = 0;  // stall cycles still to go, counted by the receiver

  int err_count = 0;

  // ---- shadow copy of the block's registers and state ----
  logic [hbs_pkg::ROWS_CFG_W-1:0] cfg_rows   = hbs_pkg::GRID_ROWS_RST;
  logic [hbs_pkg::COLS_CFG_W-1:0] cfg_cols   = hbs_pkg::GRID_COLS_RST;
  logic [hbs_pkg::SCALE_W-1:0]    cfg_scale  = hbs_pkg::HEIGHT_SCALE_RST;
  logic [hbs_pkg::OFFSET_W-1:0]   cfg_offset = hbs_pkg::HEIGHT_OFFSET_RST;
  logic [hbs_pkg::SAMPLE_W-1:0]   upper_line  [hbs_pkg::MAX_COLS] = '{default: '0};
  logic [hbs_pkg::SAMPLE_W-1:0]   middle_line [hbs_pkg::MAX_COLS] = '{default: '0};
  // [row r-2..r][col c-2..c]
  logic [hbs_pkg::SAMPLE_W-1:0]   win [3][3] = '{default: '{default: '0}};
  int unsigned                    row_pos = 0;
  int unsigned                    col_pos = 0;

  height_rec_t pending_heights[$];
  height_rec_t want;

  heightmap_box_smoother_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // mean of window rows top..2, columns left..2, scaled and offset
  function automatic void push_mean(input int top, input int left, input bit last);
    int unsigned       total;
    int unsigned       cnt;
    longint unsigned   prod;
    longint unsigned   mean;
    longint            val;
    height_rec_t       rec;
    total = 0;
    cnt   = 0;
    for (int i = top; i < 3; i++) begin
      for (int j = left; j < 3; j++) begin
        total += win[i][j];
        cnt++;
      end
    end
    prod = longint'(total) * cfg_scale;
    mean = (prod + cnt / 2) / cnt;           // round to nearest, halves up
    val  = longint'(mean);
    val  = val + $signed(cfg_offset);
    rec.height = val[hbs_pkg::HEIGHT_W-1:0];
    rec.last   = last;
    pending_heights.push_back(rec);
  endfunction

  // advance the shadow state by one accepted sample, queue its results
  function automatic void smooth_sample(input logic [hbs_pkg::SAMPLE_W-1:0] s);
    int unsigned                  nrows;
    int unsigned                  ncols;
    int unsigned                  r;
    int unsigned                  c;
    logic [hbs_pkg::SAMPLE_W-1:0] a2;
    logic [hbs_pkg::SAMPLE_W-1:0] a1;
    bit                           last_row;
    bit                           last_col;
    int                           left;
    nrows = (cfg_rows == 0) ? 1 :
            ((cfg_rows > hbs_pkg::ROW_LIMIT) ? hbs_pkg::ROW_LIMIT : cfg_rows);
    ncols = (cfg_cols == 0) ? 1 :
            ((cfg_cols > hbs_pkg::MAX_COLS) ? hbs_pkg::MAX_COLS : cfg_cols);

    // a size shrunk under the counters wraps before the sample is placed
    if (col_pos >= ncols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= nrows) row_pos = 0;
    r = row_pos;
    c = col_pos;

    a2 = upper_line[c];
    a1 = middle_line[c];
    upper_line[c]  = a1;
    middle_line[c] = s;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = a2;
    win[1][2] = a1;
    win[2][2] = s;

    last_row = (r == nrows - 1);
    last_col = (c == ncols - 1);

    // column c-1: row above, then own row on the last row
    if (c >= 1) begin
      left = (c >= 2) ? 0 : 1;
      if (r >= 1) push_mean((r >= 2) ? 0 : 1, left, 1'b0);
      if (last_row) push_mean((r >= 1) ? 1 : 2, left, 1'b0);
    end
    // last column flushes itself; the final grid point comes last
    if (last_col) begin
      left = (c >= 1) ? 1 : 2;
      if (r >= 1) push_mean((r >= 2) ? 0 : 1, left, 1'b0);
      if (last_row) push_mean((r >= 1) ? 1 : 2, left, 1'b1);
    end

    col_pos = c + 1;
    if (col_pos >= ncols) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= nrows) row_pos = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // results are sampled at the edge where they are taken
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_heights.size() == 0) begin
        report_mismatch($sformatf("unexpected result height %0d last %0b",
                                  $signed(m_axis_tdata[hbs_pkg::HEIGHT_W-1:0]),
                                  m_axis_tlast));
      end else begin
        want = pending_heights.pop_front();
        if (m_axis_tdata[hbs_pkg::HEIGHT_W-1:0] !== want.height)
          report_mismatch($sformatf("height got %0d want %0d",
                                    $signed(m_axis_tdata[hbs_pkg::HEIGHT_W-1:0]),
                                    $signed(want.height)));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("end_of_grid got %0b want %0b",
                                    m_axis_tlast, want.last));
        if (m_axis_tdata[hbs_pkg::OUT_TDATA_W-1:hbs_pkg::HEIGHT_W] !== '0)
          report_mismatch($sformatf("tdata fill bits not zero: %h", m_axis_tdata));
      end
    end
  end

  // receiver: random stalls, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (sink_hold_req != 0) begin
      sink_hold_left = sink_hold_req;
      sink_hold_req  = 0;
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(sink_gaps && $urandom_range(99) < 15);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one sample until taken; valid stays high for a following item
  task automatic send_sample(input logic [hbs_pkg::SAMPLE_W-1:0] s);
    if (src_gaps && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk); while (!s_axis_tready);
    smooth_sample(s);
  endtask

  // mostly random bytes, with the extremes mixed in
  function automatic logic [hbs_pkg::SAMPLE_W-1:0] pick_sample();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 8) return '0;
    if (k < 16) return '1;
    return hbs_pkg::SAMPLE_W'($urandom());
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_sample(pick_sample());
  endtask

  // stop offering, wait for every expected result, then let the block settle
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input hbs_pkg::cfg_reg_t idx,
                           input logic [hbs_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      hbs_pkg::REG_GRID_ROWS:     cfg_rows   = val[hbs_pkg::ROWS_CFG_W-1:0];
      hbs_pkg::REG_GRID_COLS:     cfg_cols   = val[hbs_pkg::COLS_CFG_W-1:0];
      hbs_pkg::REG_HEIGHT_SCALE:  cfg_scale  = val[hbs_pkg::SCALE_W-1:0];
      hbs_pkg::REG_HEIGHT_OFFSET: cfg_offset = val[hbs_pkg::OFFSET_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input int rows, input int cols);
    write_reg(hbs_pkg::REG_GRID_ROWS, hbs_pkg::CFG_W'(rows));
    write_reg(hbs_pkg::REG_GRID_COLS, hbs_pkg::CFG_W'(cols));
  endtask

  task automatic set_random_scaling();
    write_reg(hbs_pkg::REG_HEIGHT_SCALE, hbs_pkg::CFG_W'($urandom_range(0, 4095)));
    write_reg(hbs_pkg::REG_HEIGHT_OFFSET, hbs_pkg::CFG_W'($urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // corners, edges, interior, one-row and one-column grids, output extremes
  task automatic test_directed_edges();
    logic [hbs_pkg::SAMPLE_W-1:0] pat [12] = '{8'd0, 8'd255, 8'd17, 8'd200,
                                               8'd255, 8'd0, 8'd128, 8'd64,
                                               8'd1, 8'd254, 8'd99, 8'd7};
    // 3x4 grid at the reset scale and offset
    set_grid(3, 4);
    foreach (pat[i]) send_sample(pat[i]);
    wait_results_done();
    // largest possible height: full bytes, top scale, top offset
    set_grid(2, 3);
    write_reg(hbs_pkg::REG_HEIGHT_SCALE, hbs_pkg::CFG_W'(4095));
    write_reg(hbs_pkg::REG_HEIGHT_OFFSET, hbs_pkg::CFG_W'(24'h7FFFFF));
    repeat (6) send_sample(8'd255);
    wait_results_done();
    // smallest height from a single-row grid: zero scale, bottom offset
    set_grid(1, 3);
    write_reg(hbs_pkg::REG_HEIGHT_SCALE, hbs_pkg::CFG_W'(0));
    write_reg(hbs_pkg::REG_HEIGHT_OFFSET, hbs_pkg::CFG_W'(24'h800000));
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd0);
    wait_results_done();
    // zero sizes act as one: a single-point grid
    set_grid(0, 0);
    write_reg(hbs_pkg::REG_HEIGHT_SCALE, hbs_pkg::CFG_W'(257));
    write_reg(hbs_pkg::REG_HEIGHT_OFFSET, hbs_pkg::CFG_W'(24'hFFFF00));
    send_sample(8'd200);
    wait_results_done();
    // single column
    set_grid(3, 1);
    send_sample(8'd10);
    send_sample(8'd255);
    send_sample(8'd3);
    wait_results_done();
  endtask

  // small random grids, some sent twice back to back, random idling
  task automatic test_random_grids();
    int sent = 0;
    int rows;
    int cols;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    while (sent < 30) begin
      rows = $urandom_range(1, 4);
      cols = $urandom_range(1, 6);
      wait_results_done();
      set_grid(rows, cols);
      set_random_scaling();
      repeat ($urandom_range(1, 2)) begin
        send_random(rows * cols);
        sent += rows * cols;
      end
    end
    wait_results_done();
  endtask

  // a long stretch at full rate on both sides
  task automatic test_full_rate();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    set_grid(4, 10);
    set_random_scaling();
    send_random(4 * 10);
    wait_results_done();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering; then the sender
  // pauses mid-grid until every result is out
  task automatic test_backpressure();
    src_gaps = 1'b0;
    set_grid(4, 5);
    set_random_scaling();
    sink_hold_req = 200;
    send_random(20);
    wait_results_done();
    src_gaps = 1'b1;
    send_random(8);
    wait_results_done();
    send_random(12);
    wait_results_done();
  endtask

  // oversize sizes; each grid is then cut back so that it ends
  task automatic test_size_extremes();
    set_grid(8191, 3);        // clamps to the row limit, no row is last yet
    set_random_scaling();
    send_random(12);          // stops at row 4, column 0
    wait_results_done();
    write_reg(hbs_pkg::REG_GRID_ROWS, hbs_pkg::CFG_W'(5));   // row 4 is last
    send_random(3);
    wait_results_done();
    set_grid(2, 1023);        // clamps to the line store depth
    set_random_scaling();
    send_random(8);           // stops at row 0, column 8
    wait_results_done();
    write_reg(hbs_pkg::REG_GRID_COLS, hbs_pkg::CFG_W'(10));
    send_random(12);
    wait_results_done();
  endtask

  // sizes changed under running counters; the line store columns used here
  // were all written by earlier grids, so wrapped positions read defined data
  task automatic test_resize_midgrid();
    set_grid(5, 6);
    set_random_scaling();
    send_random(15);          // stops at row 2, column 3
    wait_results_done();
    write_reg(hbs_pkg::REG_GRID_COLS, hbs_pkg::CFG_W'(2));   // column wraps to the next row
    send_random(3);
    wait_results_done();
    write_reg(hbs_pkg::REG_GRID_COLS, hbs_pkg::CFG_W'(9));   // wider than the rows above it
    send_random(11);
    wait_results_done();
    write_reg(hbs_pkg::REG_GRID_ROWS, hbs_pkg::CFG_W'(2));   // row beyond the new height
    send_random(20);
    wait_results_done();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_random_grids();
    test_full_rate();
    test_backpressure();
    test_size_extremes();
    test_resize_midgrid();
    wait_results_done();
    if (err_count == 0) begin
      $display("heightmap_box_smoother_top_tb: clean");
    end else begin
      $display("heightmap_box_smoother_top_tb: errors");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("heightmap_box_smoother_top_tb: errors");
    $finish;
  end

endmodule

// ===== heightmap_box_smoother_top.f =====
src/hbs_pkg.sv
src/hbs_line_store.sv
src/hbs_col_cell.sv
src/hbs_scale_pipe.sv
src/heightmap_box_smoother_top.sv
tb/heightmap_box_smoother_top_tb.sv
